// ----- design/hssg_pkg.sv -----
package hssg_pkg;

	localparam int HSSG_SAMPLES_PER_PERIOD = 512;
	localparam int HSSG_SINE_FRACTION_BITS = 15;
	localparam int MASK_W = 4;
	localparam int AMP_W = 9;
	localparam int SAMPLE_W = 10;
	localparam int PHASE_OUT_W = 9;
	localparam int DAC_W = 16;
	localparam int DAC_SHIFT = 6;
	localparam int SAMPLE_OFFSET = 512;
	localparam int SAMPLE_MAX = 1023;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	typedef logic [AMP_W-1:0] amp_t;

	// output amplitude picked by the whole harmonic mask
	localparam amp_t AMP_TABLE [16] = '{
		9'd0,   9'd511, 9'd511, 9'd290, 9'd511, 9'd265, 9'd290, 9'd228,
		9'd511, 9'd257, 9'd265, 9'd185, 9'd290, 9'd186, 9'd228, 9'd204
	};

	// sine magnitude for a Q2.30 angle in [0, pi/2], taylor series through t^11,
	// rounded half up to frac bits and saturated; used at elaboration only
	function automatic longint unsigned sine_mag(longint unsigned t, int frac);
		longint unsigned w;
		longint unsigned acc;
		longint unsigned s;
		longint unsigned mag;
		longint unsigned limit;
		w = (t * t) >> 30;
		acc = ONE_Q30;
		acc = ONE_Q30 - ((w * acc) >> 30) / 110;
		acc = ONE_Q30 - ((w * acc) >> 30) / 72;
		acc = ONE_Q30 - ((w * acc) >> 30) / 42;
		acc = ONE_Q30 - ((w * acc) >> 30) / 20;
		acc = ONE_Q30 - ((w * acc) >> 30) / 6;
		s = (t * acc) >> 30;
		mag = (s + (64'd1 << (29 - frac))) >> (30 - frac);
		limit = (64'd1 << frac) - 64'd1;
		if (mag > limit) begin
			mag = limit;
		end
		return mag;
	endfunction

endpackage

// ----- design/harmonic_sine_sample_generator.sv -----
// Harmonic sine sample generator: every accepted word on the input channel makes one
// converter sample. A phase counter steps through SAMPLES_PER_PERIOD steps and wraps;
// restart_phase set in a word puts the phase back to zero for that sample. Harmonics
// 1, 2, 4 and 8 are enabled by the bits of harmonic_mask, written through cfg_we and
// cfg_wdata; the user must do so only while the block is idle, which the block
// itself does not enforce. Their sines come from a quarter-wave constant table built
// at elaboration, are summed, scaled by a mask-selected amplitude, truncated toward
// zero, offset by 512 and clamped to 0..1023. The block is a three-register pipeline
// (input, harmonic sum, scaled result) and takes a new word every cycle unless
// out_ready stalls it; the single multiplier in the last stage sets the clock.
// SAMPLES_PER_PERIOD must be a multiple of four.
module harmonic_sine_sample_generator
	import hssg_pkg::*;
#(
	parameter int SAMPLES_PER_PERIOD = HSSG_SAMPLES_PER_PERIOD,
	parameter int SINE_FRACTION_BITS = HSSG_SINE_FRACTION_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [MASK_W-1:0]      cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   restart_phase,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DAC_W-1:0]       dac_register_word,
	output logic [SAMPLE_W-1:0]    sample_value,
	output logic [PHASE_OUT_W-1:0] phase_index,
	output logic                   period_end
);

	localparam int PW = $clog2(SAMPLES_PER_PERIOD);
	localparam int XW = PW + 3;
	localparam int QN = SAMPLES_PER_PERIOD / 4;
	localparam int QW = $clog2(QN + 1);
	localparam int FW = SINE_FRACTION_BITS;
	localparam int SW = FW + 3;
	localparam int PRW = SW + AMP_W + 1;
	localparam int RW = PRW - FW;

	localparam logic [PW-1:0] LAST_PHASE = PW'(SAMPLES_PER_PERIOD - 1);
	localparam logic [PW:0] N_D = (PW + 1)'(SAMPLES_PER_PERIOD);
	localparam logic [XW-1:0] N_X = XW'(SAMPLES_PER_PERIOD);
	localparam logic [XW-1:0] TWO_N_X = XW'(2 * SAMPLES_PER_PERIOD);
	localparam logic signed [PRW-1:0] TRUNC_BIAS = PRW'((64'd1 << FW) - 64'd1);
	localparam logic signed [RW-1:0] OFFSET_R = RW'(SAMPLE_OFFSET);
	localparam logic signed [RW-1:0] MAX_R = RW'(SAMPLE_MAX);

	// quarter-wave table, entry q holds sin(pi/2 * q / QN)
	logic [FW-1:0] sine_rom [QN+1];

	for (genvar g = 0; g <= QN; g++) begin : g_rom
		localparam longint unsigned X = 4 * g;
		localparam longint unsigned T = (HALF_PI_Q30 * X) / SAMPLES_PER_PERIOD;
		assign sine_rom[g] = FW'(sine_mag(T, SINE_FRACTION_BITS));
	end

	logic [MASK_W-1:0] mask_q;
	logic [PW-1:0]     phase_q;

	logic              valid_s1;
	logic [PW-1:0]     phase_s1;
	logic              valid_s2;
	logic [PW-1:0]     phase_s2;
	logic [MASK_W-1:0] mask_s2;
	logic signed [SW-1:0] sum_s2;
	logic              valid_s3;
	logic [PW-1:0]     phase_s3;
	logic [SAMPLE_W-1:0] sample_s3;

	logic ready_s2;
	logic ready_s3;
	logic accept;
	logic [PW-1:0] phase_now;
	logic [PW-1:0] phase_next;
	logic signed [SW-1:0] sum_d;
	logic [SAMPLE_W-1:0] sample_d;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = !valid_s1 || ready_s2;
	assign accept = in_valid && in_ready;

	assign phase_now = restart_phase ? '0 : phase_q;
	assign phase_next = (phase_now == LAST_PHASE) ? '0 : phase_now + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_next;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phase_s1 <= phase_now;
		end
		if (ready_s2 && valid_s1) begin
			phase_s2 <= phase_s1;
			mask_s2 <= mask_q;
			sum_s2 <= sum_d;
		end
		if (ready_s3 && valid_s2) begin
			phase_s3 <= phase_s2;
			sample_s3 <= sample_d;
		end
	end

	// harmonic steps by modular doubling, then fold to a quarter wave and look up
	always_comb begin
		logic [PW-1:0] idx [4];
		logic [PW:0] dbl;
		logic [XW-1:0] x;
		logic neg;
		logic [QW-1:0] q;
		logic signed [SW-1:0] term;
		idx[0] = phase_s1;
		for (int k = 1; k < 4; k++) begin
			dbl = {idx[k-1], 1'b0};
			if (dbl >= N_D) begin
				dbl = dbl - N_D;
			end
			idx[k] = dbl[PW-1:0];
		end
		sum_d = '0;
		for (int k = 0; k < 4; k++) begin
			x = {1'b0, idx[k], 2'b00};
			neg = 1'b0;
			if (x >= TWO_N_X) begin
				neg = 1'b1;
				x = x - TWO_N_X;
			end
			if (x > N_X) begin
				x = TWO_N_X - x;
			end
			q = QW'(x >> 2);
			term = $signed({3'b000, sine_rom[q]});
			if (neg) begin
				term = -term;
			end
			if (mask_q[k]) begin
				sum_d = sum_d + term;
			end
		end
	end

	// scale, truncate toward zero, offset and clamp
	always_comb begin
		logic signed [PRW-1:0] prod;
		logic signed [PRW-1:0] biased;
		logic signed [RW-1:0] quot;
		logic signed [RW-1:0] value;
		prod = PRW'(sum_s2) * $signed({1'b0, AMP_TABLE[mask_s2]});
		biased = prod[PRW-1] ? prod + TRUNC_BIAS : prod;
		quot = RW'(biased >>> FW);
		value = quot + OFFSET_R;
		if (value < 0) begin
			sample_d = '0;
		end else if (value > MAX_R) begin
			sample_d = SAMPLE_W'(SAMPLE_MAX);
		end else begin
			sample_d = value[SAMPLE_W-1:0];
		end
	end

	assign out_valid = valid_s3;
	assign sample_value = sample_s3;
	assign dac_register_word = {sample_s3, DAC_SHIFT'(0)};
	assign phase_index = PHASE_OUT_W'(phase_s3);
	assign period_end = (phase_s3 == LAST_PHASE);

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= LAST_PHASE)
		else $error("phase counter out of range");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart_phase |=> phase_s1 == '0)
		else $error("restart did not zero phase");

	a_mask_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && mask_s2 == '0 |-> sum_s2 == '0)
		else $error("harmonic sum nonzero with empty mask");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s2 |=> valid_s2 && $stable(sum_s2) && $stable(phase_s2))
		else $error("stalled sum stage changed");
`endif

endmodule
